// ----- rtl/dlb_pkg.sv -----
// Package for the dense layer backprop core: item kinds, field widths,
// fixed-point limits. No dependencies.
package dlb_pkg;
    localparam logic [1:0] KIND_WR_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_LD_ACT    = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;
    localparam logic [1:0] KIND_RD_WEIGHT = 2'd3;

    localparam logic RES_WEIGHT = 1'b0;
    localparam logic RES_GRAD   = 1'b1;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;

    localparam int ACC_W = 40;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [15:0] value;
        logic               last_error;
    } t_in_beat;

    typedef struct packed {
        logic               result_kind;
        logic [5:0]         out_index;
        logic signed [15:0] out_value;
        logic               last;
    } t_out_beat;

    // command sent to every cell of the row
    typedef struct packed {
        logic               upd;   // accumulate and update weight
        logic               emit;  // gradient taken, clear accumulator
        logic signed [15:0] err;
        logic signed [15:0] w;
        logic [15:0]        lr;
    } t_cell_cmd;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7fff;
        if (v < -48'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction
endpackage

// ----- rtl/dlb_stream_if.sv -----
// Valid/ready stream interface carrying one beat payload.
// Depends on nothing; payload type is a parameter.
interface dlb_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dlb_cell.sv -----
// One column cell: holds activation and gradient accumulator, computes the
// weight update over a two-stage pipeline. Depends on dlb_pkg.
module dlb_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_act_we,
    input  logic signed [15:0]     i_act,
    input  dlb_pkg::t_cell_cmd     i_cmd,
    output logic signed [15:0]     o_new_w,
    output logic                   o_upd,
    output logic signed [15:0]     o_grad
);
    import dlb_pkg::*;
    logic signed [15:0] r_act;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_ew, r_ea;
    logic signed [15:0] r_w;
    logic [15:0] r_lr;
    logic r_upd, r_upd2;
    logic signed [47:0] r_d;
    logic signed [15:0] r_w2;
    logic signed [ACC_W:0] n_sum;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [48:0] n_dr;
    logic signed [ACC_W:0] n_gr;

    always_ff @(posedge i_clk) begin
        if (i_act_we) r_act <= i_act;
        r_ew <= i_cmd.err * i_cmd.w;
        r_ea <= i_cmd.err * r_act;
        r_w  <= i_cmd.w;
        r_lr <= i_cmd.lr;
        r_d  <= r_ea * $signed({1'b0, r_lr});
        r_w2 <= r_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= 1'b0; r_upd2 <= 1'b0;
            r_acc <= '0;
        end else begin
            r_upd <= i_cmd.upd;
            r_upd2 <= r_upd;
            if (i_cmd.emit) r_acc <= '0;
            else if (r_upd) r_acc <= n_acc;
        end
    end

    always_comb begin
        n_sum = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r_ew);
        if (n_sum[ACC_W] != n_sum[ACC_W-1])
            n_acc = n_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            n_acc = n_sum[ACC_W-1:0];
        n_dr = ($signed({r_d[47], r_d}) + 49'sd134217728) >>> 28;
        n_gr = ($signed({r_acc[ACC_W-1], r_acc}) + (ACC_W+1)'(2048)) >>> 12;
    end

    assign o_new_w = sat16(48'(r_w2) - 48'(n_dr));
    assign o_upd   = r_upd2;
    assign o_grad  = sat16(48'(n_gr));
endmodule

// ----- rtl/dense_layer_backprop_core.sv -----
// Dense layer backprop core. A sequencer walks the row of column cells, one
// column per cycle, with weights in a local memory. Depends on dlb_pkg,
// dlb_stream_if and dlb_cell.
//
// Usage: i_in carries beats {kind,row,col,value,last_error}; o_out carries
// {result_kind,out_index,out_value,last}. Config writes via i_cfg_we,
// i_cfg_idx, i_cfg_data while idle.
// Sequencing: weight write and activation load are taken while idle. A read
// holds the input through S_RD and S_RD2; its result is then registered.
// An error element holds the input while S_UPD walks the columns through
// the weight memory port and S_DRAIN lets the cell pipeline and weight
// write-back finish (a row beyond rows skips the walk); with last_error it
// then streams cols gradient beats, one per cycle unless the receiver
// stalls, which holds the walk. Reset clears the accumulators, control and
// the registers to 64/64/655; weights and activations are undefined until
// written. A stalled result holds in the output register; the block waits.
module dense_layer_backprop_core #(
    parameter int ROWS_MAX = 64,
    parameter int COLS_MAX = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dlb_stream_if.sink   i_in,
    dlb_stream_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import dlb_pkg::*;
    localparam int CW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int RW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int AW = RW + CW;
    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_RD2 = 3'd2,
                           S_UPD = 3'd3, S_DRAIN = 3'd4, S_EMIT = 3'd5;

    logic [6:0] r_rows, r_cols;
    logic [15:0] r_lr;
    logic [2:0] r_st;
    t_in_beat r_it;
    logic [CW:0] r_c;
    logic [2:0] r_dr;
    logic signed [15:0] mem [ROWS_MAX*COLS_MAX];
    logic signed [15:0] r_q;
    logic r_qv;
    logic [CW-1:0] r_qc;
    logic [CW:0] ncols;
    logic [7:0] nrows;
    t_in_beat ib;
    t_out_beat r_ob;
    logic r_ov;

    t_cell_cmd cmd [COLS_MAX];
    logic signed [15:0] nw [COLS_MAX];
    logic upd [COLS_MAX];
    logic signed [15:0] gr [COLS_MAX];
    logic [CW-1:0] r_wc [2];

    assign ib = i_in.data;
    always_comb begin
        ncols = (r_cols == 0) ? (CW+1)'(1) :
                (32'(r_cols) > COLS_MAX) ? (CW+1)'(COLS_MAX) : (CW+1)'(r_cols);
        nrows = (r_rows == 0) ? 8'd1 : (32'(r_rows) > ROWS_MAX) ? 8'(ROWS_MAX) : {1'b0, r_rows};
    end

    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic signed [15:0] mem_wd;
    logic [AW-1:0] rd_a;
    logic out_free;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_st == S_IDLE) && out_free;

    always_comb begin
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
        if (i_in.valid && i_in.ready && ib.kind == KIND_WR_WEIGHT
            && 32'(ib.row_index) < ROWS_MAX && 32'(ib.col_index) < COLS_MAX) begin
            mem_we = 1'b1;
            mem_wa = {RW'(ib.row_index), CW'(ib.col_index)};
            mem_wd = ib.value;
        end else begin
            for (int k = 0; k < COLS_MAX; k++)
                if (upd[k]) begin
                    mem_we = 1'b1;
                    mem_wa = {RW'(r_it.row_index), r_wc[1]};
                    mem_wd = nw[k];
                end
        end
        rd_a = (r_st == S_RD || r_st == S_RD2) ? {RW'(r_it.row_index), CW'(r_it.col_index)}
                                               : {RW'(r_it.row_index), r_c[CW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_q <= mem[rd_a];
        r_qc <= r_c[CW-1:0];
        r_wc[0] <= r_qc; r_wc[1] <= r_wc[0];
    end

    genvar g;
    generate
        for (g = 0; g < COLS_MAX; g++) begin : g_cell
            always_comb begin
                cmd[g].upd  = r_qv && (r_qc == CW'(g));
                cmd[g].emit = (r_st == S_EMIT) && out_free
                              && ((r_c[CW-1:0] == CW'(g)) || (r_c + 1'b1 == ncols));
                cmd[g].err  = r_it.value;
                cmd[g].w    = r_q;
                cmd[g].lr   = r_lr;
            end
            dlb_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_act_we(i_in.valid && i_in.ready && ib.kind == KIND_LD_ACT
                          && ib.col_index == 6'(g)),
                .i_act(ib.value), .i_cmd(cmd[g]),
                .o_new_w(nw[g]), .o_upd(upd[g]), .o_grad(gr[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64; r_cols <= 7'd64; r_lr <= 16'd655;
            r_st <= S_IDLE; r_ov <= 1'b0; r_qv <= 1'b0; r_c <= '0; r_dr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: r_rows <= i_cfg_data[6:0];
                    REG_COLS: r_cols <= i_cfg_data[6:0];
                    REG_RATE: r_lr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ov && o_out.ready) r_ov <= 1'b0;
            r_qv <= (r_st == S_UPD);
            case (r_st)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_it <= ib; r_c <= '0;
                    if (ib.kind == KIND_RD_WEIGHT) r_st <= S_RD;
                    else if (ib.kind == KIND_ERROR)
                        r_st <= ({2'b0, ib.row_index} < nrows) ? S_UPD :
                                ib.last_error ? S_DRAIN : S_IDLE;
                end
                S_RD: r_st <= S_RD2;
                S_RD2: if (out_free) begin
                    r_ov <= 1'b1;
                    r_ob <= '{RES_WEIGHT, r_it.col_index,
                              (32'(r_it.row_index) < ROWS_MAX && 32'(r_it.col_index) < COLS_MAX)
                              ? r_q : 16'sd0, 1'b1};
                    r_st <= S_IDLE;
                end
                S_UPD: begin
                    if (r_c + 1'b1 == ncols) begin r_st <= S_DRAIN; r_dr <= '0; end
                    else r_c <= r_c + 1'b1;
                end
                S_DRAIN: begin
                    r_dr <= r_dr + 1'b1;
                    if (r_dr == 3'd5) begin
                        r_c <= '0;
                        r_st <= r_it.last_error ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: if (out_free) begin
                    r_ov <= 1'b1;
                    r_ob <= '{RES_GRAD, 6'(r_c[CW-1:0]), gr[r_c[CW-1:0]],
                              r_c + 1'b1 == ncols};
                    if (r_c + 1'b1 == ncols) r_st <= S_IDLE;
                    else r_c <= r_c + 1'b1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_ob;
endmodule
